### hdl/packet_size_rate_adapter_macros.svh
// ----------------------------------------------------------------------------
// packet_size_rate_adapter_macros.svh
// assertion macros for the checker of the rate adapter
// ----------------------------------------------------------------------------
`ifndef PACKET_SIZE_RATE_ADAPTER_MACROS_SVH
`define PACKET_SIZE_RATE_ADAPTER_MACROS_SVH

// property must hold at every clock edge out of reset
`define PSRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression must never be true at a clock edge out of reset
`define PSRA_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

### hdl/psra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psra_pkg
// types and constants of the packet size rate adapter
// ----------------------------------------------------------------------------
package psra_pkg;

    // field and register widths
    localparam int FUNC_W    = 2;
    localparam int SIZE_W    = 16;
    localparam int TARGET_W  = 40;
    localparam int BYTES_W   = 40;
    localparam int PKTS_W    = 32;
    localparam int BITS_W    = 43;
    localparam int DIFF_W    = 44;
    localparam int DIVD_W    = 38;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 40;
    localparam int OUT_TDATA_W = 64;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_SENT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SIZE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 1'b1;

    // sizes
    localparam logic [SIZE_W-1:0] MIN_SIZE   = 16'd16;
    localparam logic [SIZE_W-1:0] SAT_SIZE   = 16'hFFFF;
    localparam logic [SIZE_W-1:0] MAX_RESET  = 16'd1024;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    // counter update request
    typedef struct packed {
        logic              sent;
        logic              tick;
        logic [SIZE_W-1:0] bytes;
    } t_cnt_ctrl;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### hdl/packet_size_rate_adapter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_size_rate_adapter
// picks the next packet size so that a traffic source tracks a target rate
// ----------------------------------------------------------------------------
// channel     | direction | tdata (low bit up)                   | tuser
// s_axis      | in        | sent_bytes[15:0]                     | func[1:0]
// m_axis      | out       | pkt_size[15:0], last_second_bits     | -
//                           [58:16], zero pad [63:59]
// cfg         | in        | index 0 target rate, index 1 max size
//
// a sent event, tick or short-cut size request goes from accept to S_DONE and
// then to the output register; a request that divides first passes S_DIV and
// the 38-step bit-serial divider; one item is in flight at a time, and the next
// is taken while the result still waits on m_axis; reset is synchronous, active low
// ----------------------------------------------------------------------------
module packet_size_rate_adapter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input requests
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [psra_pkg::SIZE_W-1:0]           i_s_axis_tdata,  // sent_bytes
    input  logic [psra_pkg::FUNC_W-1:0]           i_s_axis_tuser,  // func
    // results
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [psra_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,  // pkt_size, last_second_bits
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [psra_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [psra_pkg::CFG_DAT_W-1:0]        i_cfg_data
);

    psra_pkg::t_state r_state, n_state;

    logic [psra_pkg::TARGET_W-1:0] r_target;
    logic [psra_pkg::SIZE_W-1:0]   r_max;
    logic                          r_started;
    logic                          r_over;
    logic [psra_pkg::SIZE_W-1:0]   r_size;
    logic                          r_out_valid;
    logic [psra_pkg::SIZE_W-1:0]   r_out_size;
    logic [psra_pkg::BITS_W-1:0]   r_out_bits;

    logic                          w_accept;
    logic                          w_load_out;
    logic                          w_shortcut;
    logic                          w_negative;
    logic                          w_div_start;
    logic [psra_pkg::DIFF_W-1:0]   w_diff;
    logic [psra_pkg::SIZE_W-1:0]   w_clamp;
    logic [psra_pkg::BITS_W-1:0]   w_prev_bits;
    logic [psra_pkg::PKTS_W-1:0]   w_prev_pkts;
    logic [psra_pkg::DIVD_W-1:0]   w_quo;
    psra_pkg::t_cnt_ctrl           w_cnt_ctrl;
    psra_pkg::t_div_stat           w_div_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_max    <= psra_pkg::MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psra_pkg::CFG_TARGET: r_target <= i_cfg_data;
                psra_pkg::CFG_MAX:    r_max    <= i_cfg_data[psra_pkg::SIZE_W-1:0];
                default:              r_target <= r_target;
            endcase
        end
    end

    // counters
    assign w_cnt_ctrl.sent  = w_accept && (i_s_axis_tuser == psra_pkg::FUNC_SENT);
    assign w_cnt_ctrl.tick  = w_accept && (i_s_axis_tuser == psra_pkg::FUNC_TICK);
    assign w_cnt_ctrl.bytes = i_s_axis_tdata;

    psra_counters u_counters (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_cnt_ctrl),
        .o_prev_bits    (w_prev_bits),
        .o_prev_packets (w_prev_pkts)
    );

    // 2*target - last bits, and the cases that need no division
    assign w_diff     = {3'b000, r_target, 1'b0} - {1'b0, w_prev_bits};
    assign w_negative = w_diff[psra_pkg::DIFF_W-1];
    assign w_shortcut = (r_target == '0) || !r_started
                     || (w_prev_bits == '0) || (w_prev_pkts == '0);
    assign w_div_start = w_accept && (i_s_axis_tuser == psra_pkg::FUNC_SIZE)
                      && !w_shortcut && !w_negative;

    // quotient is (2*target - bits) / 8 / packets
    psra_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_diff[psra_pkg::DIVD_W+2:3]),
        .i_divisor  (w_prev_pkts),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    // clamp the quotient
    always_comb begin
        if (r_over) begin
            if (w_quo[psra_pkg::DIVD_W-1:psra_pkg::SIZE_W] != '0) begin
                w_clamp = psra_pkg::SAT_SIZE;
            end else if (w_quo[psra_pkg::SIZE_W-1:0] < psra_pkg::MIN_SIZE) begin
                w_clamp = psra_pkg::MIN_SIZE;
            end else begin
                w_clamp = w_quo[psra_pkg::SIZE_W-1:0];
            end
        end else begin
            if (w_quo > {{(psra_pkg::DIVD_W - psra_pkg::SIZE_W){1'b0}}, r_max}) begin
                w_clamp = r_max;
            end else begin
                w_clamp = w_quo[psra_pkg::SIZE_W-1:0];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psra_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_div_start ? psra_pkg::S_DIV : psra_pkg::S_DONE;
                end
            end
            psra_pkg::S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = psra_pkg::S_DONE;
                end
            end
            psra_pkg::S_DONE: begin
                if (w_load_out) begin
                    n_state = psra_pkg::S_IDLE;
                end
            end
            default: n_state = psra_pkg::S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_s_axis_tready = (r_state == psra_pkg::S_IDLE);
        w_load_out      = (r_state == psra_pkg::S_DONE) && (!r_out_valid || i_m_axis_tready);
    end

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psra_pkg::S_IDLE;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && (i_s_axis_tuser == psra_pkg::FUNC_SIZE) && (r_target != '0)) begin
                r_started <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result size
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_over <= ({3'b000, r_target} < w_prev_bits);
            if (i_s_axis_tuser != psra_pkg::FUNC_SIZE) begin
                r_size <= '0;
            end else if (w_shortcut) begin
                r_size <= r_max;
            end else begin
                r_size <= psra_pkg::MIN_SIZE;
            end
        end else if (w_div_stat.done) begin
            r_size <= w_clamp;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_size <= r_size;
            r_out_bits <= w_prev_bits;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(psra_pkg::OUT_TDATA_W - psra_pkg::BITS_W - psra_pkg::SIZE_W){1'b0}},
                              r_out_bits, r_out_size};

endmodule

### hdl/psra_counters.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psra_counters
// per-second byte and packet counters with the latched previous second
// ----------------------------------------------------------------------------
module psra_counters (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psra_pkg::t_cnt_ctrl           i_ctrl,
    output logic [psra_pkg::BITS_W-1:0]   o_prev_bits,
    output logic [psra_pkg::PKTS_W-1:0]   o_prev_packets
);

    logic [psra_pkg::BYTES_W-1:0] r_cur_bytes, n_cur_bytes;
    logic [psra_pkg::PKTS_W-1:0]  r_cur_pkts, n_cur_pkts;
    logic [psra_pkg::BITS_W-1:0]  r_prev_bits, n_prev_bits;
    logic [psra_pkg::PKTS_W-1:0]  r_prev_pkts, n_prev_pkts;
    logic [psra_pkg::BYTES_W:0]   w_sum;

    // saturating sum of bytes
    assign w_sum = {1'b0, r_cur_bytes}
                 + {{(psra_pkg::BYTES_W + 1 - psra_pkg::SIZE_W){1'b0}}, i_ctrl.bytes};

    // next counter values
    always_comb begin
        n_cur_bytes = r_cur_bytes;
        n_cur_pkts  = r_cur_pkts;
        n_prev_bits = r_prev_bits;
        n_prev_pkts = r_prev_pkts;
        if (i_ctrl.sent) begin
            n_cur_bytes = w_sum[psra_pkg::BYTES_W] ? '1 : w_sum[psra_pkg::BYTES_W-1:0];
            if (r_cur_pkts != '1) begin
                n_cur_pkts = r_cur_pkts + 1'b1;
            end
        end else if (i_ctrl.tick) begin
            n_prev_bits = {r_cur_bytes, 3'b000};
            n_prev_pkts = r_cur_pkts;
            n_cur_bytes = '0;
            n_cur_pkts  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_bytes <= '0;
            r_cur_pkts  <= '0;
            r_prev_bits <= '0;
            r_prev_pkts <= '0;
        end else begin
            r_cur_bytes <= n_cur_bytes;
            r_cur_pkts  <= n_cur_pkts;
            r_prev_bits <= n_prev_bits;
            r_prev_pkts <= n_prev_pkts;
        end
    end

    assign o_prev_bits    = r_prev_bits;
    assign o_prev_packets = r_prev_pkts;

endmodule

### hdl/psra_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psra_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module psra_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [psra_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [psra_pkg::PKTS_W-1:0]   i_divisor,
    output psra_pkg::t_div_stat           o_stat,
    output logic [psra_pkg::DIVD_W-1:0]   o_quotient
);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [psra_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [psra_pkg::PKTS_W-1:0]  r_rem, n_rem;
    logic [psra_pkg::DIVD_W-1:0]  r_quo, n_quo;
    logic [psra_pkg::PKTS_W-1:0]  r_div, n_div;
    logic [psra_pkg::PKTS_W:0]    w_trial;
    logic [psra_pkg::PKTS_W:0]    w_diff;
    logic                         w_qbit;

    // one trial subtract per cycle
    assign w_trial = {r_rem, r_quo[psra_pkg::DIVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_qbit  = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = psra_pkg::CNT_W'(psra_pkg::DIVD_W - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_qbit ? w_diff[psra_pkg::PKTS_W-1:0] : w_trial[psra_pkg::PKTS_W-1:0];
            n_quo = {r_quo[psra_pkg::DIVD_W-2:0], w_qbit};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

### hdl/psra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psra_checker
// port-level assertions on the packet size rate adapter
// ----------------------------------------------------------------------------
`include "packet_size_rate_adapter_macros.svh"

module psra_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    input  logic                                  o_s_axis_tready,
    input  logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    input  logic [psra_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int PAD_W = psra_pkg::OUT_TDATA_W - psra_pkg::BITS_W - psra_pkg::SIZE_W;

    logic               w_s_fire;
    logic               w_stall;
    logic [PAD_W-1:0]   w_pad;
    logic [2:0]         w_bits_low;

    // handshake and field views of the ports
    assign w_s_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_stall    = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_pad      = o_m_axis_tdata[psra_pkg::OUT_TDATA_W-1:psra_pkg::SIZE_W+psra_pkg::BITS_W];
    assign w_bits_low = o_m_axis_tdata[psra_pkg::SIZE_W +: 3];

    // one request in flight: ready drops right after an accept
    `PSRA_ASSERT(a_one_in_flight, w_s_fire |=> !o_s_axis_tready, "ready stayed high after accept")

    // a stalled result stays valid and holds its data
    `PSRA_ASSERT(a_valid_hold, w_stall |=> o_m_axis_tvalid, "stalled result dropped")
    `PSRA_ASSERT(a_data_hold, w_stall |=> $stable(o_m_axis_tdata), "stalled result changed")

    // pad bits stay zero
    `PSRA_ASSERT_NEVER(a_pad_zero, o_m_axis_tvalid && (w_pad != '0), "pad bits of result set")

    // bit count is bytes times eight
    `PSRA_ASSERT_NEVER(a_bits_byte, o_m_axis_tvalid && (w_bits_low != '0), "bits not whole bytes")

endmodule

bind packet_size_rate_adapter psra_checker u_psra_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// regression bench for the packet size rate adapter
// ----------------------------------------------------------------------------
// sends packet-sent events, one-second ticks and size requests in bursts with
// random gaps, stalls the result stream on changing patterns and checks each
// result against a cycle-free model of the counters and of the size formula;
// the target rate and the size cap change between phases while the block is
// idle, and two phases hold the result side off long enough to back up input
// ----------------------------------------------------------------------------
module tb;

    localparam logic [psra_pkg::FUNC_W-1:0]   FUNC_UNUSED    = 2'd3;
    localparam int                            LONG_HOLD      = 300;
    localparam int                            WATCHDOG_LIMIT = 4000;
    localparam int                            END_WAIT       = 60;
    localparam int                            RAND_ITEMS     = 1330;
    localparam int                            PHASE_ITEMS    = 100;
    localparam longint                        FLOOR_SIZE     = longint'(psra_pkg::MIN_SIZE);
    localparam longint                        CEIL_SIZE      = longint'(psra_pkg::SAT_SIZE);
    localparam logic [psra_pkg::TARGET_W-1:0] TARGET_FULL    = '1;

    typedef struct packed {
        logic [psra_pkg::FUNC_W-1:0] func;
        logic [psra_pkg::SIZE_W-1:0] bytes;
    } t_rate_req;

    typedef struct packed {
        logic [psra_pkg::SIZE_W-1:0] size;
        logic [psra_pkg::BITS_W-1:0] bits;
    } t_rate_result;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_COMB
    } t_rx_mode;

    // block ports
    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [psra_pkg::SIZE_W-1:0]      i_s_axis_tdata = '0;   // sent_bytes
    logic [psra_pkg::FUNC_W-1:0]      i_s_axis_tuser = '0;   // func
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [psra_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;        // pkt_size, last_second_bits
    logic                             i_cfg_we = 1'b0;
    logic [psra_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [psra_pkg::CFG_DAT_W-1:0]   i_cfg_data = '0;

    // predicted register and counter state
    logic [psra_pkg::TARGET_W-1:0]    rate_target = '0;
    logic [psra_pkg::SIZE_W-1:0]      size_max = psra_pkg::MAX_RESET;
    logic [psra_pkg::BYTES_W-1:0]     cur_bytes = '0;
    logic [psra_pkg::PKTS_W-1:0]      cur_pkts = '0;
    logic [psra_pkg::BITS_W-1:0]      last_bits = '0;
    logic [psra_pkg::PKTS_W-1:0]      last_pkts = '0;
    logic                             size_started = 1'b0;

    // queues and bookkeeping
    t_rate_req              pending_q[$];
    t_rate_result           results_q[$];
    int                     items_queued = 0;
    int                     items_taken = 0;
    int                     results_seen = 0;
    int                     size_reqs = 0;
    int                     fail_count = 0;
    int                     idle_cycles = 0;
    int                     hold_asked = 0;
    logic                   req_taken = 1'b0;

    packet_size_rate_adapter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // counter update and size pick for one accepted request
    function automatic t_rate_result adapter_step(logic [psra_pkg::FUNC_W-1:0] func,
                                                  logic [psra_pkg::SIZE_W-1:0] bytes);
        t_rate_result r;
        logic [psra_pkg::BYTES_W:0] sum;
        longint t_l, b_l, p_l, m_l, sz;
        r.size = '0;
        case (func)
            psra_pkg::FUNC_SENT: begin
                sum = (psra_pkg::BYTES_W + 1)'(cur_bytes) + (psra_pkg::BYTES_W + 1)'(bytes);
                cur_bytes = sum[psra_pkg::BYTES_W] ? '1 : sum[psra_pkg::BYTES_W-1:0];
                if (cur_pkts != '1) cur_pkts = cur_pkts + 1'b1;
            end
            psra_pkg::FUNC_TICK: begin
                // bytes times eight
                last_bits = {cur_bytes, 3'b000};
                last_pkts = cur_pkts;
                cur_bytes = '0;
                cur_pkts = '0;
            end
            psra_pkg::FUNC_SIZE: begin
                if (rate_target == '0) begin
                    r.size = size_max;
                end else if (!size_started) begin
                    size_started = 1'b1;
                    r.size = size_max;
                end else if (last_bits == '0 || last_pkts == '0) begin
                    r.size = size_max;
                end else begin
                    t_l = longint'(rate_target);
                    b_l = longint'(last_bits);
                    p_l = longint'(last_pkts);
                    m_l = longint'(size_max);
                    sz = ((2 * t_l - b_l) / p_l) / 8;
                    if (t_l < b_l) begin
                        // over target: floor, and saturate
                        if (sz < FLOOR_SIZE) sz = FLOOR_SIZE;
                        if (sz > CEIL_SIZE) sz = CEIL_SIZE;
                    end else begin
                        if (sz > m_l) sz = m_l;
                        if (sz < 0) sz = 0;
                    end
                    r.size = sz[psra_pkg::SIZE_W-1:0];
                end
            end
            default: begin
            end
        endcase
        r.bits = last_bits;
        return r;
    endfunction

    task automatic queue_req(input logic [psra_pkg::FUNC_W-1:0] func,
                             input logic [psra_pkg::SIZE_W-1:0] bytes);
        t_rate_req q;
        q.func = func;
        q.bytes = bytes;
        pending_q.push_back(q);
        items_queued++;
    endtask

    task automatic write_reg(input logic [psra_pkg::CFG_IDX_W-1:0] idx,
                             input logic [psra_pkg::CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every queued request is taken and answered
    task automatic drain_results;
        while (items_taken != items_queued || results_q.size() != 0) @(negedge i_clk);
    endtask

    // sample handshakes, predict and check
    always @(posedge i_clk) begin
        t_rate_result got, want;
        logic s_fire, m_fire;
        s_fire = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        m_fire = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        req_taken <= s_fire;
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_index)
                psra_pkg::CFG_TARGET: rate_target = i_cfg_data[psra_pkg::TARGET_W-1:0];
                psra_pkg::CFG_MAX:    size_max = i_cfg_data[psra_pkg::SIZE_W-1:0];
                default: begin
                end
            endcase
        end
        if (m_fire) begin
            got.size = o_m_axis_tdata[psra_pkg::SIZE_W-1:0];
            got.bits = o_m_axis_tdata[psra_pkg::SIZE_W +: psra_pkg::BITS_W];
            if (results_q.size() == 0) begin
                $error("result with nothing pending: tdata %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = results_q.pop_front();
                results_seen++;
                if (got.size !== want.size) begin
                    $error("pkt_size mismatch: expected %0d, got %0d", want.size, got.size);
                    fail_count++;
                end
                if (got.bits !== want.bits) begin
                    $error("last_second_bits mismatch: expected %0d, got %0d",
                           want.bits, got.bits);
                    fail_count++;
                end
            end
        end
        if (s_fire) begin
            results_q.push_back(adapter_step(i_s_axis_tuser, i_s_axis_tdata));
            items_taken++;
            if (i_s_axis_tuser == psra_pkg::FUNC_SIZE) size_reqs++;
        end
        if (s_fire || m_fire || i_cfg_we) idle_cycles = 0;
        else idle_cycles++;
    end

    // request driver: bursts of random length, random gaps between them
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        t_rate_req nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || req_taken) begin
            if (gap_left > 0 || pending_q.size() == 0) begin
                i_s_axis_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                nxt = pending_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= nxt.bytes;
                i_s_axis_tuser <= nxt.func;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
                    if ($urandom_range(0, 15) == 0) gap_left = $urandom_range(15, 40);
                end
            end
        end
    end

    // result side: stall pattern, picked again at random among four modes
    t_rx_mode rx_mode = RX_OPEN;
    int mode_left = 0;
    int hold_left = 0;
    int hold_served = 0;
    int rx_cycle = 0;
    always @(negedge i_clk) begin
        rx_cycle++;
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 200);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   i_m_axis_tready <= 1'b1;
                RX_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
                default:   i_m_axis_tready <= (rx_cycle % 5 != 0);
            endcase
        end
    end

    // watchdog on cycles with no handshake at all
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("packet_size_rate_adapter regression: fail");
        $finish;
    end

    // stimulus
    initial begin
        int phase_count;
        int rand_stop, phase_stop;
        int bsize, burst_pkts, lo, hi, n, i;
        longint nominal;
        logic [psra_pkg::TARGET_W-1:0] tgt_val;
        logic [psra_pkg::SIZE_W-1:0] max_val;

        phase_count = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero target always answers the cap, odd code does nothing
        queue_req(psra_pkg::FUNC_SIZE, 16'hFFFF);
        queue_req(FUNC_UNUSED, 16'h0000);
        queue_req(psra_pkg::FUNC_SENT, 16'h0000);
        queue_req(psra_pkg::FUNC_SENT, 16'hFFFF);
        queue_req(psra_pkg::FUNC_TICK, 16'h5A5A);
        queue_req(psra_pkg::FUNC_SIZE, 16'hA5A5);
        queue_req(FUNC_UNUSED, 16'hFFFF);
        drain_results;

        // first request, empty second, over target, with the cap at its largest
        write_reg(psra_pkg::CFG_TARGET, 40'd1000000);
        write_reg(psra_pkg::CFG_MAX, psra_pkg::CFG_DAT_W'(psra_pkg::SAT_SIZE));
        queue_req(psra_pkg::FUNC_SIZE, 16'h0000);
        queue_req(psra_pkg::FUNC_SIZE, 16'h0000);
        queue_req(psra_pkg::FUNC_TICK, 16'h0000);
        queue_req(psra_pkg::FUNC_SIZE, 16'h0000);
        queue_req(psra_pkg::FUNC_SENT, 16'hFFFF);
        queue_req(psra_pkg::FUNC_SENT, 16'h5555);
        queue_req(psra_pkg::FUNC_SENT, 16'hAAAA);
        queue_req(psra_pkg::FUNC_TICK, 16'hFFFF);
        queue_req(psra_pkg::FUNC_SIZE, 16'hFFFF);
        // one zero-byte packet: no bits counted
        queue_req(psra_pkg::FUNC_SENT, 16'h0000);
        queue_req(psra_pkg::FUNC_TICK, 16'h0000);
        queue_req(psra_pkg::FUNC_SIZE, 16'h0000);
        drain_results;

        // widest target with the smallest cap
        write_reg(psra_pkg::CFG_TARGET, TARGET_FULL);
        write_reg(psra_pkg::CFG_MAX, psra_pkg::CFG_DAT_W'(psra_pkg::MIN_SIZE));
        queue_req(psra_pkg::FUNC_SENT, 16'hFFFF);
        queue_req(psra_pkg::FUNC_TICK, 16'h0000);
        queue_req(psra_pkg::FUNC_SIZE, 16'h0000);
        drain_results;

        // tiny target: negative numerator floors at the minimum size
        write_reg(psra_pkg::CFG_TARGET, 40'd1);
        queue_req(psra_pkg::FUNC_SIZE, 16'h0000);
        drain_results;

        // random phases, one register setting each
        rand_stop = items_queued + RAND_ITEMS;
        while (items_queued < rand_stop) begin
            case ($urandom_range(0, 9))
                0, 1:    bsize = $urandom_range(16, 64);
                2, 3, 4, 5, 6: bsize = $urandom_range(64, 1500);
                default: bsize = $urandom_range(1500, 65535);
            endcase
            burst_pkts = $urandom_range(1, 10);
            nominal = longint'(bsize) * 8 * burst_pkts;
            case ($urandom_range(0, 9))
                0:       tgt_val = '0;
                1:       tgt_val = {8'($urandom_range(0, 255)), $urandom};
                2:       tgt_val = TARGET_FULL;
                default: tgt_val = psra_pkg::TARGET_W'(nominal * $urandom_range(1, 16) / 4);
            endcase
            case ($urandom_range(0, 5))
                0:       max_val = psra_pkg::MIN_SIZE;
                1:       max_val = psra_pkg::SAT_SIZE;
                2:       max_val = psra_pkg::MAX_RESET;
                default: max_val = 16'($urandom_range(16, 65535));
            endcase
            write_reg(psra_pkg::CFG_TARGET, tgt_val);
            write_reg(psra_pkg::CFG_MAX, psra_pkg::CFG_DAT_W'(max_val));

            // seconds of traffic around the nominal packet size
            lo = bsize / 2;
            hi = (bsize * 2 > 65535) ? 65535 : bsize * 2;
            phase_stop = items_queued + PHASE_ITEMS;
            while (items_queued < phase_stop && items_queued < rand_stop) begin
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2 * burst_pkts);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        queue_req(psra_pkg::FUNC_SENT, 16'($urandom));
                    end else begin
                        queue_req(psra_pkg::FUNC_SENT, 16'($urandom_range(lo, hi)));
                    end
                    if ($urandom_range(0, 3) == 0) queue_req(psra_pkg::FUNC_SIZE, 16'($urandom));
                    if ($urandom_range(0, 31) == 0) queue_req(FUNC_UNUSED, 16'($urandom));
                end
                // now and then a missed tick merges two seconds
                if ($urandom_range(0, 7) != 0) queue_req(psra_pkg::FUNC_TICK, 16'($urandom));
                repeat ($urandom_range(1, 3)) queue_req(psra_pkg::FUNC_SIZE, 16'($urandom));
            end

            // hold results off while requests keep coming
            if (phase_count == 2 || phase_count == 7) hold_asked++;
            drain_results;
            phase_count++;
        end

        drain_results;
        repeat (END_WAIT) @(posedge i_clk);
        if (results_q.size() != 0) begin
            $error("%0d results never arrived", results_q.size());
            fail_count++;
        end

        $display("covered %0d requests (%0d size requests) and checked %0d results",
                 items_taken, size_reqs, results_seen);
        $display("over %0d register settings, %0d failures", phase_count + 4, fail_count);
        if (fail_count == 0) begin
            $display("packet_size_rate_adapter regression: pass");
        end else begin
            $display("packet_size_rate_adapter regression: fail");
        end
        $finish;
    end

endmodule
